// ----- sv/svp_pkg.sv -----
// ----------------------------------------------------------------------------
// svp_pkg: shared types, constants and the CRC step of the packet validator
// Holds the frame byte codes, the status codes, the verdict word layout and
// the byte-wise CRC-16/XMODEM update.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int COUNT_W = 17;
    localparam int POS_W   = 18;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0]  START_SHORT = 8'h02;
    localparam logic [7:0]  START_LONG  = 8'h03;
    localparam logic [7:0]  STOP_BYTE   = 8'h03;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_TOP     = 16'h8000;

    // Header sizes and minimum total lengths for the two frame forms.
    localparam logic [POS_W-1:0]   OFFSET_SHORT = 18'd2;
    localparam logic [POS_W-1:0]   OFFSET_LONG  = 18'd3;
    localparam logic [COUNT_W-1:0] EXTRA_SHORT  = 17'd5;
    localparam logic [COUNT_W-1:0] EXTRA_LONG   = 17'd6;
    localparam logic [COUNT_W-1:0] MIN_LEN      = 17'd5;
    localparam logic [COUNT_W-1:0] MIN_LEN_LONG = 17'd6;

    typedef enum logic [2:0] {
        ST_VALID      = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_LONG_SHORT = 3'd2,
        ST_BAD_START  = 3'd3,
        ST_INCOMPLETE = 3'd4,
        ST_BAD_STOP   = 3'd5,
        ST_CRC_BAD    = 3'd6
    } t_status;

    typedef struct packed {
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic [15:0] payload_length;
        logic [7:0]  command_byte;
        t_status     status;
    } t_verdict;

    localparam int VERDICT_W = $bits(t_verdict);
    localparam int TDATA_W   = ((VERDICT_W + 7) / 8) * 8;

    // One byte through CRC-16/XMODEM, MSB first.
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/svp_tracker.sv -----
// ----------------------------------------------------------------------------
// svp_tracker: frame position tracking and verdict logic
// Captures header, payload CRC, trailer CRC and stop byte as words pass, and
// forms the verdict for the word flagged last. State clears after a verdict.
// ----------------------------------------------------------------------------
module svp_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output svp_pkg::t_verdict    o_verdict
);

    logic [svp_pkg::COUNT_W-1:0] r_count,    n_count,    u_count;
    logic [7:0]                  r_first,    n_first,    u_first;
    logic [15:0]                 r_len,      n_len,      u_len;
    logic [15:0]                 r_crc,      n_crc,      u_crc;
    logic [15:0]                 r_fcrc,     n_fcrc,     u_fcrc;
    logic [7:0]                  r_stop,     n_stop,     u_stop;
    logic [7:0]                  r_cmd,      n_cmd,      u_cmd;

    logic                        is_short;
    logic                        is_long;
    logic [svp_pkg::POS_W-1:0]   pos;
    logic [svp_pkg::POS_W-1:0]   offset;
    logic [svp_pkg::POS_W-1:0]   crc_pos;
    logic                        u_short;
    logic                        u_long;
    logic [svp_pkg::COUNT_W-1:0] expected;
    svp_pkg::t_status            status;

    always_comb begin
        is_short = (r_first == svp_pkg::START_SHORT);
        is_long  = (r_first == svp_pkg::START_LONG);
        pos      = {1'b0, r_count};
        offset   = is_short ? svp_pkg::OFFSET_SHORT : svp_pkg::OFFSET_LONG;
        crc_pos  = offset + {2'b00, r_len};

        u_count = r_count;
        u_first = r_first;
        u_len   = r_len;
        u_crc   = r_crc;
        u_fcrc  = r_fcrc;
        u_stop  = r_stop;
        u_cmd   = r_cmd;

        if (i_accept) begin
            if (r_count == '0) begin
                u_first = i_byte;
            end else if (is_short || is_long) begin
                if (is_short && pos == 18'd1) begin
                    u_len = {8'h00, i_byte};
                end else if (is_long && pos == 18'd1) begin
                    u_len = {i_byte, 8'h00};
                end else if (is_long && pos == 18'd2) begin
                    u_len = {r_len[15:8], i_byte};
                end
                if (pos >= offset) begin
                    if (pos == offset) begin
                        u_cmd = i_byte;
                    end
                    // Payload bytes feed the CRC; the trailer and stop are captured.
                    if (pos < crc_pos) begin
                        u_crc = svp_pkg::crc_update(r_crc, i_byte);
                    end else if (pos == crc_pos) begin
                        u_fcrc = {i_byte, 8'h00};
                    end else if (pos == crc_pos + 18'd1) begin
                        u_fcrc = {r_fcrc[15:8], i_byte};
                    end else if (pos == crc_pos + 18'd2) begin
                        u_stop = i_byte;
                    end
                end
            end
            if (r_count != svp_pkg::COUNT_MAX) begin
                u_count = r_count + 17'd1;
            end
        end
    end

    always_comb begin
        u_short  = (u_first == svp_pkg::START_SHORT);
        u_long   = (u_first == svp_pkg::START_LONG);
        expected = {1'b0, u_len} + (u_short ? svp_pkg::EXTRA_SHORT : svp_pkg::EXTRA_LONG);
        if (u_count < svp_pkg::MIN_LEN) begin
            status = svp_pkg::ST_TOO_SHORT;
        end else if (!(u_short || u_long)) begin
            status = svp_pkg::ST_BAD_START;
        end else if (u_long && u_count < svp_pkg::MIN_LEN_LONG) begin
            status = svp_pkg::ST_LONG_SHORT;
        end else if (u_count < expected) begin
            status = svp_pkg::ST_INCOMPLETE;
        end else if (u_stop != svp_pkg::STOP_BYTE) begin
            status = svp_pkg::ST_BAD_STOP;
        end else if (u_crc != u_fcrc) begin
            status = svp_pkg::ST_CRC_BAD;
        end else begin
            status = svp_pkg::ST_VALID;
        end
        o_verdict.status         = status;
        o_verdict.command_byte   = u_cmd;
        o_verdict.payload_length = u_len;
        o_verdict.computed_crc   = u_crc;
        o_verdict.received_crc   = u_fcrc;
    end

    // The word flagged last closes the buffer, so everything starts over.
    always_comb begin
        if (i_accept && i_last) begin
            n_count = '0;
            n_first = '0;
            n_len   = '0;
            n_crc   = '0;
            n_fcrc  = '0;
            n_stop  = '0;
            n_cmd   = '0;
        end else begin
            n_count = u_count;
            n_first = u_first;
            n_len   = u_len;
            n_crc   = u_crc;
            n_fcrc  = u_fcrc;
            n_stop  = u_stop;
            n_cmd   = u_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_first <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_fcrc  <= '0;
            r_stop  <= '0;
            r_cmd   <= '0;
        end else begin
            r_count <= n_count;
            r_first <= n_first;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_fcrc  <= n_fcrc;
            r_stop  <= n_stop;
            r_cmd   <= n_cmd;
        end
    end

endmodule

// ----- sv/serial_packet_validator_core.sv -----
// ----------------------------------------------------------------------------
// serial_packet_validator_core: byte-serial framed packet checker
//
//   Channel  | Dir | Word contents
//   ---------+-----+----------------------------------------------------------
//   s_axis   | in  | tdata: rx_byte; tlast: last_of_buffer
//   m_axis   | out | tdata: status, command_byte, payload_length,
//            |     |        computed_crc, received_crc (one word per buffer)
//
// One byte is taken every cycle while not blocked; the CRC step and the frame
// checks settle within the cycle a byte is accepted. The verdict for a buffer
// appears in the output register in the cycle after its last byte. A held
// verdict blocks new bytes only while the output side stalls. Reset is
// synchronous and clears all frame state and the output valid flag.
// ----------------------------------------------------------------------------
module serial_packet_validator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,  // [7:0] rx_byte
    input  logic                         i_s_axis_tlast,  // last_of_buffer
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [2:0] status, [10:3] command_byte, [26:11] payload_length,
    // [42:27] computed_crc, [58:43] received_crc, [63:59] zero
    output logic [svp_pkg::TDATA_W-1:0]  o_m_axis_tdata
);

    logic                               accept;
    svp_pkg::t_verdict                  verdict;
    logic                               r_valid, n_valid;
    logic [svp_pkg::VERDICT_W-1:0]      r_data,  n_data;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    svp_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_verdict (verdict)
    );

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (r_valid && i_m_axis_tready) begin
            n_valid = 1'b0;
        end
        if (accept && i_s_axis_tlast) begin
            n_valid = 1'b1;
            n_data  = verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {{(svp_pkg::TDATA_W - svp_pkg::VERDICT_W){1'b0}}, r_data};

endmodule
